>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the permutation engine checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define XPE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define XPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/xpe_pkg.sv
// ----------------------------------------------------------------------------
// xpe_pkg
// Types, codes and round constants of the Xoodoo-384 permutation engine
// ----------------------------------------------------------------------------
package xpe_pkg;

  localparam int unsigned LaneW     = 32;
  localparam int unsigned LaneCount = 12;

  typedef logic [LaneW-1:0]                lane_t;
  typedef logic [LaneCount-1:0][LaneW-1:0] lanes_t;

  // item modes carried in tuser
  typedef enum logic [1:0] {
    MODE_XOR     = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_PERMUTE = 2'd3
  } mode_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_EMIT
  } fsm_t;

  localparam logic [3:0] LastLane  = 4'd11;
  localparam logic [3:0] LastRcIdx = 4'd11;
  localparam logic [3:0] RcCount   = 4'd12;

  // round constant list, the last n entries serve an n-round permutation
  function automatic lane_t rc_lookup(input logic [3:0] idx);
    lane_t rc;
    unique case (idx)
      4'd0:    rc = 32'h0000_0058;
      4'd1:    rc = 32'h0000_0038;
      4'd2:    rc = 32'h0000_03C0;
      4'd3:    rc = 32'h0000_00D0;
      4'd4:    rc = 32'h0000_0120;
      4'd5:    rc = 32'h0000_0014;
      4'd6:    rc = 32'h0000_0060;
      4'd7:    rc = 32'h0000_002C;
      4'd8:    rc = 32'h0000_0380;
      4'd9:    rc = 32'h0000_00F0;
      4'd10:   rc = 32'h0000_01A0;
      4'd11:   rc = 32'h0000_0012;
      default: rc = '0;
    endcase
    return rc;
  endfunction

  // fixed-amount left rotate
  function automatic lane_t rotl(input lane_t v, input int unsigned s);
    lane_t r;
    r = (s % LaneW == 0) ? v : ((v << (s % LaneW)) | (v >> (LaneW - (s % LaneW))));
    return r;
  endfunction

endpackage

>>> src/xoodoo_permutation_engine_top.sv
// ----------------------------------------------------------------------------
// xoodoo_permutation_engine_top
// Xoodoo-384 state with lane load/xor/clear and an iterative permutation
//
//  channel  dir  tdata (low bit up)                    side
//  in_      in   lane_select[3:0], lane_data[35:4]     tuser[1:0] = mode
//  out_     out  out_lane[3:0], out_word[35:4]         tlast = out_last
//  cfg_     in   round_count[3:0]                      write on cfg_we
//
//  xor, load and clear beats leave the engine ready for the next beat
//  a permute runs n rounds (one round per cycle through the shared round
//  unit, n = round count saturated at MAX_ROUND_COUNT) and then twelve beats
//  of emission, each beat held until out_tready
//  in_tready is low from a permute beat until the last lane is taken
//  reset clears all lanes and sets the round count to twelve
// ----------------------------------------------------------------------------
module xoodoo_permutation_engine_top #(
  parameter int unsigned MAX_ROUND_COUNT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // lane_select[3:0], lane_data[35:4], zero pad
  input  logic [1:0]  in_tuser,   // mode[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_lane[3:0], out_word[35:4], zero pad
  output logic        out_tlast,
  // round count register
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam logic [3:0] MaxRounds = 4'(MAX_ROUND_COUNT);

  xpe_pkg::lanes_t lanes_r, lanes_nxt, round_out;
  xpe_pkg::fsm_t   fsm_r, fsm_nxt;
  logic [3:0]      round_count_r, round_count_nxt;
  logic [3:0]      cidx_r, cidx_nxt;
  logic [3:0]      emit_r, emit_nxt;
  logic [3:0]      n_eff;
  logic [3:0]      in_sel;
  xpe_pkg::lane_t  in_data;
  xpe_pkg::mode_t  in_mode;
  logic            in_fire;

  assign in_sel  = in_tdata[3:0];
  assign in_data = in_tdata[35:4];
  assign in_mode = xpe_pkg::mode_t'(in_tuser);
  assign in_fire = in_tvalid && in_tready;
  assign n_eff   = (round_count_r > MaxRounds) ? MaxRounds : round_count_r;

  // shared round unit
  xpe_round u_round (
    .state_i (lanes_r),
    .rc_i    (xpe_pkg::rc_lookup(cidx_r)),
    .state_o (round_out)
  );

  // result stream always shows lane zero of the rotating state
  assign out_tvalid = (fsm_r == xpe_pkg::ST_EMIT);
  assign out_tdata  = {4'b0, lanes_r[0], emit_r};
  assign out_tlast  = (emit_r == xpe_pkg::LastLane);
  assign in_tready  = (fsm_r == xpe_pkg::ST_IDLE);

  // register write
  assign round_count_nxt = cfg_we ? cfg_wdata : round_count_r;

  // sequencer and state update
  always_comb begin
    fsm_nxt   = fsm_r;
    lanes_nxt = lanes_r;
    cidx_nxt  = cidx_r;
    emit_nxt  = emit_r;
    unique case (fsm_r)
      xpe_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_mode)
            xpe_pkg::MODE_XOR: begin
              for (int i = 0; i < xpe_pkg::LaneCount; i++) begin
                if (in_sel == 4'(i)) lanes_nxt[i] = lanes_r[i] ^ in_data;
              end
            end
            xpe_pkg::MODE_LOAD: begin
              for (int i = 0; i < xpe_pkg::LaneCount; i++) begin
                if (in_sel == 4'(i)) lanes_nxt[i] = in_data;
              end
            end
            xpe_pkg::MODE_CLEAR: begin
              lanes_nxt = '0;
            end
            xpe_pkg::MODE_PERMUTE: begin
              emit_nxt = '0;
              cidx_nxt = xpe_pkg::RcCount - n_eff;
              fsm_nxt  = (n_eff == 4'd0) ? xpe_pkg::ST_EMIT : xpe_pkg::ST_ROUND;
            end
            default: begin
              fsm_nxt = xpe_pkg::ST_IDLE;
            end
          endcase
        end
      end
      xpe_pkg::ST_ROUND: begin
        lanes_nxt = round_out;
        cidx_nxt  = cidx_r + 4'd1;
        if (cidx_r == xpe_pkg::LastRcIdx) fsm_nxt = xpe_pkg::ST_EMIT;
      end
      xpe_pkg::ST_EMIT: begin
        if (out_tready) begin
          // rotate lanes down; after twelve beats the state is back in place
          for (int i = 0; i < xpe_pkg::LaneCount - 1; i++) begin
            lanes_nxt[i] = lanes_r[i+1];
          end
          lanes_nxt[xpe_pkg::LaneCount-1] = lanes_r[0];
          if (emit_r == xpe_pkg::LastLane) begin
            emit_nxt = '0;
            fsm_nxt  = xpe_pkg::ST_IDLE;
          end else begin
            emit_nxt = emit_r + 4'd1;
          end
        end
      end
      default: begin
        fsm_nxt = xpe_pkg::ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r         <= xpe_pkg::ST_IDLE;
      lanes_r       <= '0;
      round_count_r <= 4'd12;
      cidx_r        <= '0;
      emit_r        <= '0;
    end else begin
      fsm_r         <= fsm_nxt;
      lanes_r       <= lanes_nxt;
      round_count_r <= round_count_nxt;
      cidx_r        <= cidx_nxt;
      emit_r        <= emit_nxt;
    end
  end

endmodule

>>> src/xpe_round.sv
// ----------------------------------------------------------------------------
// xpe_round
// One Xoodoo round: theta, rho-west, iota, chi, rho-east
// ----------------------------------------------------------------------------
module xpe_round (
  input  xpe_pkg::lanes_t state_i,
  input  xpe_pkg::lane_t  rc_i,
  output xpe_pkg::lanes_t state_o
);

  xpe_pkg::lane_t p  [4];
  xpe_pkg::lane_t e  [4];
  xpe_pkg::lane_t a0 [4];
  xpe_pkg::lane_t a1 [4];
  xpe_pkg::lane_t a2 [4];
  xpe_pkg::lane_t w0 [4];
  xpe_pkg::lane_t w1 [4];
  xpe_pkg::lane_t w2 [4];
  xpe_pkg::lane_t c0 [4];
  xpe_pkg::lane_t c1 [4];
  xpe_pkg::lane_t c2 [4];

  always_comb begin
    // theta: column parity folded back with two rotations
    for (int x = 0; x < 4; x++) begin
      p[x] = state_i[x] ^ state_i[4+x] ^ state_i[8+x];
    end
    for (int x = 0; x < 4; x++) begin
      e[x] = xpe_pkg::rotl(p[(x+3)%4], 5) ^ xpe_pkg::rotl(p[(x+3)%4], 14);
    end
    for (int x = 0; x < 4; x++) begin
      a0[x] = state_i[x]   ^ e[x];
      a1[x] = state_i[4+x] ^ e[x];
      a2[x] = state_i[8+x] ^ e[x];
    end

    // rho-west and iota
    for (int x = 0; x < 4; x++) begin
      w0[x] = a0[x];
      w1[x] = a1[(x+3)%4];
      w2[x] = xpe_pkg::rotl(a2[x], 11);
    end
    w0[0] = a0[0] ^ rc_i;

    // chi
    for (int x = 0; x < 4; x++) begin
      c0[x] = w0[x] ^ (~w1[x] & w2[x]);
      c1[x] = w1[x] ^ (~w2[x] & w0[x]);
      c2[x] = w2[x] ^ (~w0[x] & w1[x]);
    end

    // rho-east
    for (int x = 0; x < 4; x++) begin
      state_o[x]   = c0[x];
      state_o[4+x] = xpe_pkg::rotl(c1[x], 1);
      state_o[8+x] = xpe_pkg::rotl(c2[(x+2)%4], 8);
    end
  end

endmodule

>>> src/xpe_checker.sv
// ----------------------------------------------------------------------------
// xpe_checker
// Port-level checks of the permutation engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  logic       in_beat, out_beat, is_permute, lane_stepped;
  logic [3:0] lane_inc_r;

  assign in_beat    = in_tvalid && in_tready;
  assign out_beat   = out_tvalid && out_tready;
  assign is_permute = (in_tuser == xpe_pkg::MODE_PERMUTE);

  // lane index expected after the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_inc_r <= '0;
    end else begin
      lane_inc_r <= out_tdata[3:0] + 4'd1;
    end
  end

  assign lane_stepped = out_tvalid && (out_tdata[3:0] == lane_inc_r);

  // no new item taken while lanes are being emitted
  `XPE_ASSERT_IMPL(a_busy_emit, clk, rst_n, out_tvalid, !in_tready)

  // lane indexes step by one within an emission run
  `XPE_ASSERT_NEXT(a_lane_step, clk, rst_n, out_beat && !out_tlast, lane_stepped)

  // the engine is idle again right after the last lane
  `XPE_ASSERT_NEXT(a_idle_after_last, clk, rst_n, out_beat && out_tlast, in_tready && !out_tvalid)

  // xor, load and clear beats leave the engine ready for the next beat
  `XPE_ASSERT_NEXT(a_short_ops, clk, rst_n, in_beat && !is_permute, in_tready)

  // a permute beat leaves the input side busy
  `XPE_ASSERT_NEXT(a_permute_busy, clk, rst_n, in_beat && is_permute, !in_tready)

endmodule

bind xoodoo_permutation_engine_top xpe_checker u_xpe_checker (.*);
